// ----- rtl/adsr_pkg.sv -----
// Shared types and constants for the ADSR envelope amplifier.
`default_nettype none

package adsr_pkg;

    // Q1.23 level format
    localparam int unsigned LEVEL_W = 24;
    localparam logic [LEVEL_W-1:0] ONE_Q23 = 24'd8388608;

    // Working width of the stage update: a 24-bit level plus or minus a 24-bit step
    localparam int unsigned ADV_W = LEVEL_W + 2;

    // Serial multiplier geometry: radix-4 digits over a 25-bit multiplier
    localparam int unsigned MUL_A_W      = LEVEL_W + 1;
    localparam int unsigned MUL_B_W      = LEVEL_W + 1;
    localparam int unsigned MUL_ACC_W    = MUL_A_W + 3;
    localparam int unsigned MUL_DIGITS   = (MUL_B_W - 1) / 2;
    localparam int unsigned MUL_CNT_W    = $clog2(MUL_DIGITS + 1);

    // Configuration register map
    localparam int unsigned APB_ADDR_W = 5;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_ATTACK_STEP   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_DECAY_STEP    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_RELEASE_STEP  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SUSTAIN_LEVEL = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ONE_SHOT      = 3'd4;

    localparam logic [LEVEL_W-1:0] RST_ATTACK_STEP   = 24'd1900;
    localparam logic [LEVEL_W-1:0] RST_DECAY_STEP    = 24'd57;
    localparam logic [LEVEL_W-1:0] RST_RELEASE_STEP  = 24'd380;
    localparam logic [LEVEL_W-1:0] RST_SUSTAIN_LEVEL = 24'd5872026;

    // Item kinds
    typedef enum logic [1:0] {
        KIND_TICK     = 2'd0,
        KIND_NOTE_ON  = 2'd1,
        KIND_NOTE_OFF = 2'd2,
        KIND_RESET    = 2'd3
    } kind_t;

    // Envelope stages
    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_ATTACK  = 3'd1,
        ST_DECAY   = 3'd2,
        ST_SUSTAIN = 3'd3,
        ST_RELEASE = 3'd4
    } stage_t;

endpackage

`default_nettype wire

// ----- rtl/adsr_ifs.sv -----
// Valid/ready channel interfaces for envelope items and results.
`default_nettype none

interface adsr_item_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic signed [23:0] sample_left;
    logic signed [23:0] sample_right;
    logic [23:0]        velocity;

    modport source (
        output valid, kind, sample_left, sample_right, velocity,
        input  ready
    );
    modport sink (
        input  valid, kind, sample_left, sample_right, velocity,
        output ready
    );
endinterface

interface adsr_result_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] out_left;
    logic signed [23:0] out_right;
    logic [23:0]        env_level;
    logic [2:0]         env_stage;
    logic               is_active;

    modport source (
        output valid, out_left, out_right, env_level, env_stage, is_active,
        input  ready
    );
    modport sink (
        input  valid, out_left, out_right, env_level, env_stage, is_active,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/adsr_smul.sv -----
// Digit-serial signed-by-unsigned multiplier returning floor(a * b / 2^24).
`default_nettype none

module adsr_smul
    import adsr_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic signed [MUL_A_W-1:0]  a,
    input  wire logic [MUL_B_W-1:0]         b,
    output logic                            done,
    output logic signed [MUL_A_W-1:0]       product
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [MUL_CNT_W-1:0]          cnt_reg, cnt_next;
    logic signed [MUL_ACC_W-1:0]   a_reg, a_next;
    logic [MUL_B_W-1:0]            b_reg, b_next;
    logic signed [MUL_ACC_W-1:0]   acc_reg, acc_next;
    logic signed [MUL_ACC_W-1:0]   pp;
    logic signed [MUL_ACC_W-1:0]   sum;

    // Partial product of the current two-bit digit of the multiplier.
    always_comb
    begin
        pp = '0;
        if (b_reg[0])
        begin
            pp = pp + a_reg;
        end
        if (b_reg[1])
        begin
            pp = pp + (a_reg <<< 1);
        end
        sum = acc_reg + pp;
    end

    // Each digit step adds and shifts right by two, which floors the dropped bits.
    // The last step adds the top multiplier bit at unit weight.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            a_next    = MUL_ACC_W'(a);
            b_next    = b;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == MUL_CNT_W'(MUL_DIGITS))
            begin
                acc_next  = b_reg[0] ? (acc_reg + a_reg) : acc_reg;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                acc_next = sum >>> 2;
                b_next   = b_reg >> 2;
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            a_reg    <= '0;
            b_reg    <= '0;
            acc_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            a_reg    <= a_next;
            b_reg    <= b_next;
            acc_reg  <= acc_next;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg[MUL_A_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/adsr_envelope_vca.sv -----
// Top level: ADSR envelope stage machine, register file and stereo amplifier.
//
//  Port    | Role            | Beat contents
//  --------+-----------------+-------------------------------------------------
//  item    | sink, valid/rdy | kind, sample_left, sample_right, velocity
//  result  | source, valid/rdy| out_left, out_right, env_level, env_stage, is_active
//  APB     | register access | attack/decay/release steps, sustain level, one-shot
//
// A sample tick goes from acceptance to the next acceptance through the stage update, then
// through two passes of the radix-4 serial multipliers (gain = level * velocity, then
// sample * gain on both lanes).
// Note on, note off and reset items bypass the multipliers.
// rst_n clears the stage machine, the envelope state and the registers to their defaults.
// A finished result waits in the output register; the next beat is accepted meanwhile,
// and its result is held back only until the output register is free.
`default_nettype none

module adsr_envelope_vca
    import adsr_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    adsr_item_if.sink                   item,
    adsr_result_if.source               result,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [APB_ADDR_W-1:0]  paddr,
    input  wire logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]       prdata,
    output logic                        pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_GAIN,
        S_AMP,
        S_DONE
    } fsm_t;

    // Configuration registers
    logic [LEVEL_W-1:0] attack_step_reg;
    logic [LEVEL_W-1:0] decay_step_reg;
    logic [LEVEL_W-1:0] release_step_reg;
    logic [LEVEL_W-1:0] sustain_level_reg;
    logic               one_shot_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_wr;

    // Control and envelope state
    fsm_t               state_reg, state_next;
    kind_t              kind_reg, kind_next;
    logic signed [23:0] samp_l_reg, samp_l_next;
    logic signed [23:0] samp_r_reg, samp_r_next;
    logic [LEVEL_W-1:0] vel_in_reg, vel_in_next;
    stage_t             stage_reg, stage_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [LEVEL_W-1:0] held_vel_reg, held_vel_next;
    logic               note_held_reg, note_held_next;
    logic signed [23:0] res_l_reg, res_l_next;
    logic signed [23:0] res_r_reg, res_r_next;

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic signed [23:0] out_left_reg, out_left_next;
    logic signed [23:0] out_right_reg, out_right_next;
    logic [LEVEL_W-1:0] out_level_reg, out_level_next;
    stage_t             out_stage_reg, out_stage_next;

    // Stage update datapath
    logic [LEVEL_W-1:0]        sus_clamped;
    logic [LEVEL_W-1:0]        step_sel;
    logic signed [ADV_W-1:0]   adv_sum;
    stage_t                    adv_stage;
    logic [LEVEL_W-1:0]        adv_level;
    logic [LEVEL_W-1:0]        vel_sat;

    // Multiplier hookup
    logic                      mul_l_start, mul_r_start;
    logic signed [MUL_A_W-1:0] mul_l_a, mul_r_a;
    logic [MUL_B_W-1:0]        mul_l_b, mul_r_b;
    logic                      mul_l_done, mul_r_done;
    logic signed [MUL_A_W-1:0] mul_l_prod, mul_r_prod;
    logic [LEVEL_W-1:0]        gain;
    logic                      out_load;

    // APB register file: pready is always high, writes land on the access cycle.
    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_step_reg   <= RST_ATTACK_STEP;
            decay_step_reg    <= RST_DECAY_STEP;
            release_step_reg  <= RST_RELEASE_STEP;
            sustain_level_reg <= RST_SUSTAIN_LEVEL;
            one_shot_reg      <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_ATTACK_STEP:   attack_step_reg   <= pwdata[LEVEL_W-1:0];
                REG_DECAY_STEP:    decay_step_reg    <= pwdata[LEVEL_W-1:0];
                REG_RELEASE_STEP:  release_step_reg  <= pwdata[LEVEL_W-1:0];
                REG_SUSTAIN_LEVEL: sustain_level_reg <= pwdata[LEVEL_W-1:0];
                REG_ONE_SHOT:      one_shot_reg      <= pwdata[0];
                default:           ;
            endcase
        end
    end

    // Register readback.
    always_comb
    begin
        unique case (reg_idx)
            REG_ATTACK_STEP:   prdata = APB_DATA_W'(attack_step_reg);
            REG_DECAY_STEP:    prdata = APB_DATA_W'(decay_step_reg);
            REG_RELEASE_STEP:  prdata = APB_DATA_W'(release_step_reg);
            REG_SUSTAIN_LEVEL: prdata = APB_DATA_W'(sustain_level_reg);
            REG_ONE_SHOT:      prdata = APB_DATA_W'(one_shot_reg);
            default:           prdata = '0;
        endcase
    end

    // Stage update for a sample tick: one add or subtract, then a clamp compare.
    always_comb
    begin
        sus_clamped = (sustain_level_reg > ONE_Q23) ? ONE_Q23 : sustain_level_reg;
        unique case (stage_reg)
            ST_ATTACK: step_sel = attack_step_reg;
            ST_DECAY:  step_sel = decay_step_reg;
            default:   step_sel = release_step_reg;
        endcase
        if (stage_reg == ST_ATTACK)
        begin
            adv_sum = signed'(ADV_W'(level_reg)) + signed'(ADV_W'(step_sel));
        end
        else
        begin
            adv_sum = signed'(ADV_W'(level_reg)) - signed'(ADV_W'(step_sel));
        end

        adv_stage = stage_reg;
        adv_level = level_reg;
        unique case (stage_reg)
            ST_ATTACK:
            begin
                if (adv_sum >= signed'(ADV_W'(ONE_Q23)))
                begin
                    adv_level = ONE_Q23;
                    adv_stage = ST_DECAY;
                end
                else
                begin
                    adv_level = adv_sum[LEVEL_W-1:0];
                end
            end
            ST_DECAY:
            begin
                if (adv_sum <= signed'(ADV_W'(sus_clamped)))
                begin
                    adv_level = sus_clamped;
                    adv_stage = one_shot_reg ? ST_RELEASE : ST_SUSTAIN;
                end
                else
                begin
                    adv_level = adv_sum[LEVEL_W-1:0];
                end
            end
            ST_SUSTAIN:
            begin
                if (!note_held_reg)
                begin
                    adv_stage = ST_RELEASE;
                end
            end
            ST_RELEASE:
            begin
                if (adv_sum <= signed'(ADV_W'(0)))
                begin
                    adv_level = '0;
                    adv_stage = ST_IDLE;
                end
                else
                begin
                    adv_level = adv_sum[LEVEL_W-1:0];
                end
            end
            default: ;
        endcase

        vel_sat = (vel_in_reg > ONE_Q23) ? ONE_Q23 : vel_in_reg;
    end

    // Left multiplier first forms the gain, then both lanes scale the samples.
    assign gain        = mul_l_prod[LEVEL_W-1:0];
    assign mul_l_start = ((state_reg == S_EXEC) && (kind_reg == KIND_TICK))
                      || ((state_reg == S_GAIN) && mul_l_done);
    assign mul_r_start = (state_reg == S_GAIN) && mul_l_done;
    assign mul_l_a     = (state_reg == S_EXEC) ? signed'(MUL_A_W'(adv_level))
                                               : MUL_A_W'(samp_l_reg);
    assign mul_l_b     = (state_reg == S_EXEC) ? {held_vel_reg, 1'b0} : {gain, 1'b0};
    assign mul_r_a     = MUL_A_W'(samp_r_reg);
    assign mul_r_b     = {gain, 1'b0};

    adsr_smul u_mul_l (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_l_start),
        .a       (mul_l_a),
        .b       (mul_l_b),
        .done    (mul_l_done),
        .product (mul_l_prod)
    );

    adsr_smul u_mul_r (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_r_start),
        .a       (mul_r_a),
        .b       (mul_r_b),
        .done    (mul_r_done),
        .product (mul_r_prod)
    );

    // Sequencer next-state and register updates.
    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        samp_l_next    = samp_l_reg;
        samp_r_next    = samp_r_reg;
        vel_in_next    = vel_in_reg;
        stage_next     = stage_reg;
        level_next     = level_reg;
        held_vel_next  = held_vel_reg;
        note_held_next = note_held_reg;
        res_l_next     = res_l_reg;
        res_r_next     = res_r_reg;
        out_left_next  = out_left_reg;
        out_right_next = out_right_reg;
        out_level_next = out_level_reg;
        out_stage_next = out_stage_reg;
        out_load       = (state_reg == S_DONE) && (!out_valid_reg || result.ready);
        out_valid_next = out_valid_reg && !result.ready;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    kind_next   = kind_t'(item.kind);
                    samp_l_next = item.sample_left;
                    samp_r_next = item.sample_right;
                    vel_in_next = item.velocity;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res_l_next = '0;
                res_r_next = '0;
                unique case (kind_reg)
                    KIND_TICK:
                    begin
                        stage_next = adv_stage;
                        level_next = adv_level;
                        state_next = S_GAIN;
                    end
                    KIND_NOTE_ON:
                    begin
                        held_vel_next  = vel_sat;
                        note_held_next = 1'b1;
                        stage_next     = ST_ATTACK;
                        state_next     = S_DONE;
                    end
                    KIND_NOTE_OFF:
                    begin
                        note_held_next = 1'b0;
                        if (stage_reg == ST_SUSTAIN)
                        begin
                            stage_next = ST_RELEASE;
                        end
                        state_next = S_DONE;
                    end
                    KIND_RESET:
                    begin
                        stage_next     = ST_IDLE;
                        level_next     = '0;
                        note_held_next = 1'b0;
                        state_next     = S_DONE;
                    end
                endcase
            end
            S_GAIN:
            begin
                if (mul_l_done)
                begin
                    state_next = S_AMP;
                end
            end
            S_AMP:
            begin
                if (mul_r_done)
                begin
                    res_l_next = mul_l_prod[23:0];
                    res_r_next = mul_r_prod[23:0];
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_left_next  = res_l_reg;
            out_right_next = res_r_reg;
            out_level_next = level_reg;
            out_stage_next = stage_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            kind_reg      <= KIND_TICK;
            samp_l_reg    <= '0;
            samp_r_reg    <= '0;
            vel_in_reg    <= '0;
            stage_reg     <= ST_IDLE;
            level_reg     <= '0;
            held_vel_reg  <= '0;
            note_held_reg <= 1'b0;
            res_l_reg     <= '0;
            res_r_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_left_reg  <= '0;
            out_right_reg <= '0;
            out_level_reg <= '0;
            out_stage_reg <= ST_IDLE;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            samp_l_reg    <= samp_l_next;
            samp_r_reg    <= samp_r_next;
            vel_in_reg    <= vel_in_next;
            stage_reg     <= stage_next;
            level_reg     <= level_next;
            held_vel_reg  <= held_vel_next;
            note_held_reg <= note_held_next;
            res_l_reg     <= res_l_next;
            res_r_reg     <= res_r_next;
            out_valid_reg <= out_valid_next;
            out_left_reg  <= out_left_next;
            out_right_reg <= out_right_next;
            out_level_reg <= out_level_next;
            out_stage_reg <= out_stage_next;
        end
    end

    // Channel outputs.
    assign item.ready       = (state_reg == S_IDLE);
    assign result.valid     = out_valid_reg;
    assign result.out_left  = out_left_reg;
    assign result.out_right = out_right_reg;
    assign result.env_level = out_level_reg;
    assign result.env_stage = out_stage_reg;
    assign result.is_active = (out_stage_reg != ST_IDLE);

endmodule

`default_nettype wire

// ----- rtl/adsr_chk.sv -----
// Port-level checker for the ADSR envelope amplifier, bound to the top level.
`default_nettype none

module adsr_chk
    import adsr_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               item_valid,
    input wire logic               item_ready,
    input wire logic               result_valid,
    input wire logic               result_ready,
    input wire logic signed [23:0] out_left,
    input wire logic signed [23:0] out_right,
    input wire logic [23:0]        env_level,
    input wire logic [2:0]         env_stage,
    input wire logic               is_active
);

    // A stalled result beat holds its value.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(env_level)
            && $stable(env_stage) && $stable(out_left) && $stable(out_right))
        else $error("result beat changed while stalled");

    // The block works on one item at a time, so it drops ready after a beat.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("item accepted while another is in flight");

    // The active flag follows the stage.
    a_active: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> is_active == (env_stage != ST_IDLE))
        else $error("is_active disagrees with env_stage");

    // An idle envelope has zero level and silent outputs.
    a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && env_stage == ST_IDLE |-> env_level == '0
            && out_left == '0 && out_right == '0)
        else $error("idle envelope is not silent");

    // The level never exceeds unity.
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> env_level <= ONE_Q23)
        else $error("envelope level above 1.0");

endmodule

bind adsr_envelope_vca adsr_chk u_adsr_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .out_left     (result.out_left),
    .out_right    (result.out_right),
    .env_level    (result.env_level),
    .env_stage    (result.env_stage),
    .is_active    (result.is_active)
);

`default_nettype wire

// ----- sim/adsr_envelope_vca_compare.sv -----
// Result predictor and comparator for the ADSR envelope amplifier channels.
`timescale 1ns / 1ps

module adsr_envelope_vca_compare
    import adsr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    adsr_item_if                  item,
    adsr_result_if                result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output int                    mismatch_count,
    output int                    outstanding
);

    // Mismatch lines beyond this count are only counted, to keep the log short.
    localparam int PRINT_CAP = 200;

    typedef struct {
        logic signed [23:0] out_left;
        logic signed [23:0] out_right;
        logic [23:0]        level;
        stage_t             stage;
        logic               active;
    } vca_beat_t;

    vca_beat_t predicted_beats[$];

    // Local copy of the register file
    logic [23:0] attack_step;
    logic [23:0] decay_step;
    logic [23:0] release_step;
    logic [23:0] sustain_level;
    logic        one_shot;

    // Local copy of the envelope state
    stage_t      env_stage;
    logic [23:0] env_level;
    logic [23:0] note_velocity;
    logic        note_held;

    task automatic report_mismatch(input string what);
        if (mismatch_count < PRINT_CAP)
            $display("%0t ns: mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // One sample of the stage machine, with the clamps at 1.0, sustain and zero.
    task automatic advance_stage();
        longint lvl;
        longint sus;
        begin
            sus = (sustain_level > ONE_Q23) ? longint'(ONE_Q23) : longint'(sustain_level);
            lvl = longint'(env_level);
            case (env_stage)
                ST_ATTACK:
                begin
                    lvl = lvl + longint'(attack_step);
                    if (lvl >= longint'(ONE_Q23))
                    begin
                        lvl = longint'(ONE_Q23);
                        env_stage = ST_DECAY;
                    end
                end
                ST_DECAY:
                begin
                    lvl = lvl - longint'(decay_step);
                    if (lvl <= sus)
                    begin
                        lvl = sus;
                        if (one_shot)
                            env_stage = ST_RELEASE;
                        else
                            env_stage = ST_SUSTAIN;
                    end
                end
                ST_SUSTAIN:
                begin
                    if (!note_held)
                        env_stage = ST_RELEASE;
                end
                ST_RELEASE:
                begin
                    lvl = lvl - longint'(release_step);
                    if (lvl <= 0)
                    begin
                        lvl = 0;
                        env_stage = ST_IDLE;
                    end
                end
                default:
                begin
                end
            endcase
            env_level = lvl[23:0];
        end
    endtask

    // Applies one item beat to the envelope state and works out its result beat.
    task automatic apply_item(input kind_t kind, input logic signed [23:0] smp_left,
                              input logic signed [23:0] smp_right,
                              input logic [23:0] velocity, output vca_beat_t want);
        longint gain;
        longint scaled_left;
        longint scaled_right;
        begin
            scaled_left = 0;
            scaled_right = 0;
            case (kind)
                KIND_TICK:
                begin
                    advance_stage();
                    // Both products truncate toward minus infinity.
                    gain = (longint'(env_level) * longint'(note_velocity)) >>> 23;
                    scaled_left = (longint'(smp_left) * gain) >>> 23;
                    scaled_right = (longint'(smp_right) * gain) >>> 23;
                end
                KIND_NOTE_ON:
                begin
                    note_velocity = (velocity > ONE_Q23) ? ONE_Q23 : velocity;
                    note_held = 1'b1;
                    env_stage = ST_ATTACK;
                end
                KIND_NOTE_OFF:
                begin
                    note_held = 1'b0;
                    if (env_stage == ST_SUSTAIN)
                        env_stage = ST_RELEASE;
                end
                default:
                begin
                    env_stage = ST_IDLE;
                    env_level = '0;
                    note_held = 1'b0;
                end
            endcase
            want.out_left = scaled_left[23:0];
            want.out_right = scaled_right[23:0];
            want.level = env_level;
            want.stage = env_stage;
            want.active = (env_stage != ST_IDLE);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        vca_beat_t want;
        if (!rst_n)
        begin
            attack_step = RST_ATTACK_STEP;
            decay_step = RST_DECAY_STEP;
            release_step = RST_RELEASE_STEP;
            sustain_level = RST_SUSTAIN_LEVEL;
            one_shot = 1'b0;
            env_stage = ST_IDLE;
            env_level = '0;
            note_velocity = '0;
            note_held = 1'b0;
            mismatch_count = 0;
            predicted_beats.delete();
            outstanding <= 0;
        end
        else
        begin
            // Result beats are matched against the oldest prediction.
            if (result.valid && result.ready)
            begin
                if (predicted_beats.size() == 0)
                    report_mismatch("result beat with no prediction waiting");
                else
                begin
                    want = predicted_beats.pop_front();
                    if (result.out_left !== want.out_left)
                        report_mismatch($sformatf("out_left %0d, predicted %0d",
                                                  result.out_left, want.out_left));
                    if (result.out_right !== want.out_right)
                        report_mismatch($sformatf("out_right %0d, predicted %0d",
                                                  result.out_right, want.out_right));
                    if (result.env_level !== want.level)
                        report_mismatch($sformatf("env_level %0d, predicted %0d",
                                                  result.env_level, want.level));
                    if (result.env_stage !== want.stage)
                        report_mismatch($sformatf("env_stage %0d, predicted %0d",
                                                  result.env_stage, want.stage));
                    if (result.is_active !== want.active)
                        report_mismatch($sformatf("is_active %0b, predicted %0b",
                                                  result.is_active, want.active));
                end
            end

            // Register writes complete in the access phase.
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    REG_ATTACK_STEP:   attack_step = pwdata[23:0];
                    REG_DECAY_STEP:    decay_step = pwdata[23:0];
                    REG_RELEASE_STEP:  release_step = pwdata[23:0];
                    REG_SUSTAIN_LEVEL: sustain_level = pwdata[23:0];
                    REG_ONE_SHOT:      one_shot = pwdata[0];
                    default:
                    begin
                    end
                endcase
            end

            // Every accepted item beat produces exactly one result beat.
            if (item.valid && item.ready)
            begin
                apply_item(kind_t'(item.kind), item.sample_left, item.sample_right,
                           item.velocity, want);
                predicted_beats.push_back(want);
            end
            outstanding <= predicted_beats.size();
        end
    end

endmodule

// ----- sim/adsr_envelope_vca_test.sv -----
// Stimulus, clock, reset and verdict for the ADSR envelope amplifier.
`timescale 1ns / 1ps

module adsr_envelope_vca_test;
    import adsr_pkg::*;

    localparam int     RANDOM_ITEMS = 1900;
    localparam int     SEGMENTS     = 18;
    localparam int     SETTLE_CYCLES = 40;
    localparam longint RUN_LIMIT_NS = 5_000_000;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int mismatch_count;
    int outstanding;
    int src_idle_pct = 30;
    int snk_idle_pct = 60;
    int beats_sent = 0;

    adsr_item_if   item_ch ();
    adsr_result_if result_ch ();

    adsr_envelope_vca u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    adsr_envelope_vca_compare u_compare (
        .clk            (clk),
        .rst_n          (rst_n),
        .item           (item_ch),
        .result         (result_ch),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Result side: ready drops at random according to the current phase.
    always @(negedge clk)
        result_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);

    // Samples lean on the extremes now and then.
    function automatic logic [23:0] rand_sample();
        logic [31:0] raw;
        begin
            raw = $urandom;
            case ($urandom_range(0, 15))
                0:       return 24'h800000;
                1:       return 24'h7FFFFF;
                2:       return 24'h000000;
                default: return raw[23:0];
            endcase
        end
    endfunction

    // Velocity: mostly in range, sometimes any 24-bit pattern to hit saturation.
    function automatic logic [23:0] rand_velocity();
        logic [31:0] raw;
        begin
            raw = $urandom;
            case ($urandom_range(0, 9))
                0:       return 24'd0;
                1:       return ONE_Q23;
                2:       return raw[23:0];
                default: return 24'($urandom_range(0, 8388608));
            endcase
        end
    endfunction

    // Steps mostly large, between 2^16 and 2^23, so notes move through their stages quickly; now and then 1 or 1.0.
    function automatic logic [23:0] rand_step();
        int sh;
        begin
            sh = $urandom_range(16, 22);
            case ($urandom_range(0, 11))
                0:       return 24'd1;
                1:       return ONE_Q23;
                default: return 24'($urandom_range(1 << sh, 1 << (sh + 1)));
            endcase
        end
    endfunction

    function automatic logic [23:0] rand_sustain();
        begin
            case ($urandom_range(0, 7))
                0:       return 24'd0;
                1:       return ONE_Q23;
                default: return 24'($urandom_range(0, 8388608));
            endcase
        end
    endfunction

    // Offers one item beat and holds it until the block takes it.
    task automatic send_beat(input kind_t kind, input logic [23:0] smp_left,
                             input logic [23:0] smp_right, input logic [23:0] velocity);
        @(negedge clk);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.kind <= kind;
        item_ch.sample_left <= smp_left;
        item_ch.sample_right <= smp_right;
        item_ch.velocity <= velocity;
        do
            @(posedge clk);
        while (!item_ch.ready);
        beats_sent++;
    endtask

    task automatic tick(input logic [23:0] smp_left, input logic [23:0] smp_right);
        send_beat(KIND_TICK, smp_left, smp_right, rand_velocity());
    endtask

    // Stops offering beats and waits for every predicted result.
    task automatic drain();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Setup phase, then access phase until pready.
    task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [23:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {8'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic load_config(input logic [23:0] attack, input logic [23:0] decay,
                               input logic [23:0] rel, input logic [23:0] sustain,
                               input logic one_shot);
        drain();
        reg_write(REG_ATTACK_STEP, attack);
        reg_write(REG_DECAY_STEP, decay);
        reg_write(REG_RELEASE_STEP, rel);
        reg_write(REG_SUSTAIN_LEVEL, sustain);
        reg_write(REG_ONE_SHOT, {23'd0, one_shot});
    endtask

    // A note: note on, some ticks, usually a note off and a release tail.
    task automatic play_phrase();
        int n;
        begin
            send_beat(KIND_NOTE_ON, rand_sample(), rand_sample(), rand_velocity());
            n = $urandom_range(1, 40);
            repeat (n) tick(rand_sample(), rand_sample());
            case ($urandom_range(0, 9))
                0: send_beat(KIND_RESET, rand_sample(), rand_sample(), rand_velocity());
                1: send_beat(kind_t'($urandom_range(0, 3)), rand_sample(), rand_sample(),
                             rand_velocity());
                2:
                begin
                    // Note stays held; the next note on retriggers mid-envelope.
                end
                default: send_beat(KIND_NOTE_OFF, rand_sample(), rand_sample(),
                                   rand_velocity());
            endcase
            n = $urandom_range(0, 30);
            repeat (n) tick(rand_sample(), rand_sample());
        end
    endtask

    initial
    begin
        int target;
        int base;
        rst_n = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.kind = KIND_TICK;
        item_ch.sample_left = '0;
        item_ch.sample_right = '0;
        item_ch.velocity = '0;
        result_ch.ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Full-scale attack, sustain above 1.0 reads as 1.0, unity gain at the extremes.
        load_config(ONE_Q23, 24'd2000000, 24'd4194304, 24'hFFFFFF, 1'b0);
        tick(24'h7FFFFF, 24'h800000);
        send_beat(KIND_NOTE_ON, 24'd0, 24'd0, 24'hFFFFFF);
        tick(24'h7FFFFF, 24'h800000);
        tick(24'h800000, 24'h7FFFFF);
        send_beat(KIND_NOTE_OFF, 24'd0, 24'd0, 24'd0);
        tick(24'hFFFFFF, 24'h000001);
        tick(24'h7FFFFF, 24'h800000);

        // One-shot: decay goes straight into release, then idle with the note still held.
        load_config(24'd3000000, ONE_Q23, ONE_Q23, 24'd4194304, 1'b1);
        send_beat(KIND_NOTE_ON, 24'd0, 24'd0, 24'h400000);
        repeat (3) tick(24'h7FFFFF, 24'h800000);
        tick(24'h123456, 24'hEDCBA9);
        tick(24'h7FFFFF, 24'h800000);
        tick(24'h7FFFFF, 24'h800000);

        // Sustain change while sustaining, a zero release step, retrigger mid-level.
        load_config(ONE_Q23, ONE_Q23, 24'd0, 24'h200000, 1'b0);
        send_beat(KIND_NOTE_ON, 24'd0, 24'd0, 24'h7FFFFF);
        tick(24'h7FFFFF, 24'h800000);
        tick(24'h7FFFFF, 24'h800000);
        drain();
        reg_write(REG_SUSTAIN_LEVEL, 24'h600000);
        tick(24'h7FFFFF, 24'h800000);
        send_beat(KIND_NOTE_OFF, 24'd0, 24'd0, 24'd0);
        tick(24'h7FFFFF, 24'h800000);
        send_beat(KIND_NOTE_ON, 24'd0, 24'd0, 24'h7FFFFF);
        tick(24'h7FFFFF, 24'h800000);

        // Note off during attack; sustain then falls into release on its first tick.
        load_config(24'd4194304, ONE_Q23, ONE_Q23, 24'h7FFFFF, 1'b0);
        send_beat(KIND_RESET, 24'd0, 24'd0, 24'd0);
        send_beat(KIND_NOTE_ON, 24'd0, 24'd0, ONE_Q23);
        send_beat(KIND_NOTE_OFF, 24'd0, 24'd0, 24'd0);
        repeat (5) tick(24'h7FFFFF, 24'h800000);

        // Random notes under a fresh register setting per segment.
        base = beats_sent;
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            case (seg / (SEGMENTS / 3))
                0:
                begin
                    src_idle_pct = 30;
                    snk_idle_pct = 60;
                end
                1:
                begin
                    src_idle_pct = 60;
                    snk_idle_pct = 30;
                end
                default:
                begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            load_config(rand_step(), rand_step(), rand_step(), rand_sustain(),
                        1'($urandom_range(0, 1)));
            target = base + ((seg + 1) * RANDOM_ITEMS) / SEGMENTS;
            while (beats_sent < target)
                play_phrase();
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #RUN_LIMIT_NS;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/adsr_pkg.sv
rtl/adsr_ifs.sv
rtl/adsr_smul.sv
rtl/adsr_envelope_vca.sv
rtl/adsr_chk.sv
sim/adsr_envelope_vca_compare.sv
sim/adsr_envelope_vca_test.sv
